FILE: hw/rtl/v3n_pkg.sv
// Shared types, widths and helpers for the 3D vector normalizer.
`default_nettype none
package v3n_pkg;

    localparam int COMP_W     = 16;
    localparam int UNIT_FRAC  = 14;
    localparam int UNIT_W     = UNIT_FRAC + 2;
    localparam int SUM_W      = 2 * COMP_W;
    localparam int ROOT_W     = COMP_W;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int QUO_W      = UNIT_FRAC + 1;
    localparam int DIV_STAGES = QUO_W;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        vec_t             vec;
    } sq_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        vec_t              vec;
    } sq_out_t;

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             neg;
    } dv_res_t;

    typedef struct packed {
        dv_res_t [2:0]     lane;
        logic [ROOT_W-1:0] len;
    } dv_out_t;

    function automatic logic [COMP_W-1:0] abs_comp(input logic signed [COMP_W-1:0] c);
        logic [COMP_W-1:0] u;
        u = c;
        abs_comp = c[COMP_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/vector3_normalize.sv
// Top level of the 3D vector normalizer.
// Usage:
//   Input channel: comp_x, comp_y, comp_z (signed Q8.8) with in_valid and
//   in_ready. Output channel: unit_x, unit_y, unit_z (signed Q2.14),
//   magnitude (unsigned Q8.8) and zero_length with out_valid and out_ready.
//   A transaction moves when valid and ready are both high at a clock edge.
// Pipeline: one stage of squaring, 16 square root stages (one root bit each),
//   15 divider stages (one quotient bit each, three lanes in parallel) and one
//   output stage.
// Throughput: one transaction per cycle while the receiver takes results.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty
//   and in_ready is high.
// Stall: when out_ready is low, results hold in the output register and
//   stages fill behind it; empty stages still accept, so in_ready drops only
//   once all 33 stages are occupied. Nothing is lost or repeated.
// A zero vector gives zero unit components, magnitude zero and
//   zero_length high.
`default_nettype none
module vector3_normalize
    import v3n_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [COMP_W-1:0] comp_x,
    input  wire logic signed [COMP_W-1:0] comp_y,
    input  wire logic signed [COMP_W-1:0] comp_z,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [UNIT_W-1:0]      unit_x,
    output logic signed [UNIT_W-1:0]      unit_y,
    output logic signed [UNIT_W-1:0]      unit_z,
    output logic [ROOT_W-1:0]             magnitude,
    output logic                          zero_length
);

    logic             a_v_reg;
    vec_t             a_vec_reg;
    logic [SUM_W-1:0] a_sq_reg [3];
    logic             a_rdy;

    sq_in_t  sq_in;
    logic    sq_in_ready;
    logic    sq_out_valid;
    sq_out_t sq_out;
    logic    dv_in_ready;
    logic    dv_out_valid;
    dv_out_t dv_out;

    logic                     f_v_reg;
    logic                     f_rdy;
    logic signed [UNIT_W-1:0] f_unit_reg [3];
    logic [ROOT_W-1:0]        f_mag_reg;
    logic                     f_zero_reg;

    logic [COMP_W-1:0] ax;
    logic [COMP_W-1:0] ay;
    logic [COMP_W-1:0] az;

    assign ax = abs_comp(comp_x);
    assign ay = abs_comp(comp_y);
    assign az = abs_comp(comp_z);

    assign a_rdy    = ~a_v_reg | sq_in_ready;
    assign in_ready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (a_rdy)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            a_vec_reg.x <= comp_x;
            a_vec_reg.y <= comp_y;
            a_vec_reg.z <= comp_z;
            a_sq_reg[0] <= ax * ax;
            a_sq_reg[1] <= ay * ay;
            a_sq_reg[2] <= az * az;
        end
    end

    assign sq_in.sum = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
    assign sq_in.vec = a_vec_reg;

    v3n_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_v_reg),
        .in_ready  (sq_in_ready),
        .in_data   (sq_in),
        .out_valid (sq_out_valid),
        .out_ready (dv_in_ready),
        .out_data  (sq_out)
    );

    v3n_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_out_valid),
        .in_ready  (dv_in_ready),
        .in_data   (sq_out),
        .out_valid (dv_out_valid),
        .out_ready (f_rdy),
        .out_data  (dv_out)
    );

    assign f_rdy = ~f_v_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (f_rdy)
        begin
            f_v_reg <= dv_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_out.len == '0)
                begin
                    f_unit_reg[i] <= '0;
                end
                else if (dv_out.lane[i].neg)
                begin
                    f_unit_reg[i] <= UNIT_W'(~{1'b0, dv_out.lane[i].q} + 1'b1);
                end
                else
                begin
                    f_unit_reg[i] <= UNIT_W'({1'b0, dv_out.lane[i].q});
                end
            end
            f_mag_reg  <= dv_out.len;
            f_zero_reg <= (dv_out.len == '0);
        end
    end

    assign out_valid   = f_v_reg;
    assign unit_x      = f_unit_reg[0];
    assign unit_y      = f_unit_reg[1];
    assign unit_z      = f_unit_reg[2];
    assign magnitude   = f_mag_reg;
    assign zero_length = f_zero_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/v3n_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module v3n_sqrt
    import v3n_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire sq_in_t  in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output sq_out_t      out_data
);

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [ROOT_W:0]   rem;
        logic [ROOT_W-1:0] root;
        vec_t              vec;
    } sq_st_t;

    function automatic sq_st_t sq_step(input sq_st_t s);
        sq_st_t            r;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] test;
        r     = s;
        trial = {s.rem, s.rad[SUM_W-1 -: 2]};
        test  = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[SUM_W-3:0], 2'b00};
        if (trial >= test)
        begin
            r.rem  = (ROOT_W+1)'(trial - test);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = trial[ROOT_W:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_st_t s_reg [SQ_STAGES];
    logic   v_reg [SQ_STAGES];
    logic   rdy   [SQ_STAGES];
    sq_st_t init;

    always_comb
    begin
        init.rad  = in_data.sum;
        init.rem  = '0;
        init.root = '0;
        init.vec  = in_data.vec;
    end

    always_comb
    begin
        rdy[SQ_STAGES-1] = out_ready | ~v_reg[SQ_STAGES-1];
        for (int k = SQ_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = ~v_reg[k] | rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s_reg[0] <= sq_step(init);
        end
        for (int k = 1; k < SQ_STAGES; k++)
        begin
            if (rdy[k])
            begin
                s_reg[k] <= sq_step(s_reg[k-1]);
            end
        end
    end

    assign out_valid     = v_reg[SQ_STAGES-1];
    assign out_data.root = s_reg[SQ_STAGES-1].root;
    assign out_data.vec  = s_reg[SQ_STAGES-1].vec;

endmodule
`default_nettype wire

FILE: hw/rtl/v3n_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
`default_nettype none
module v3n_div
    import v3n_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire sq_out_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dv_out_t      out_data
);

    typedef struct packed {
        logic [ROOT_W-1:0] r;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  q;
        logic              neg;
    } dv_lane_t;

    typedef struct packed {
        dv_lane_t [2:0]    lane;
        logic [ROOT_W-1:0] len;
    } dv_st_t;

    function automatic dv_st_t dv_step(input dv_st_t s);
        dv_st_t          r;
        logic [ROOT_W:0] t;
        r = s;
        for (int i = 0; i < 3; i++)
        begin
            t = {s.lane[i].r, s.lane[i].low[QUO_W-1]};
            r.lane[i].low = {s.lane[i].low[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, s.len})
            begin
                r.lane[i].r = ROOT_W'(t - {1'b0, s.len});
                r.lane[i].q = {s.lane[i].q[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.lane[i].r = t[ROOT_W-1:0];
                r.lane[i].q = {s.lane[i].q[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic dv_lane_t lane_init(input logic signed [COMP_W-1:0] c);
        dv_lane_t          l;
        logic [COMP_W-1:0] m;
        m     = abs_comp(c);
        l.r   = ROOT_W'(m[COMP_W-1:1]);
        l.low = {m[0], {(QUO_W-1){1'b0}}};
        l.q   = '0;
        l.neg = c[COMP_W-1];
        return l;
    endfunction

    dv_st_t s_reg [DIV_STAGES];
    logic   v_reg [DIV_STAGES];
    logic   rdy   [DIV_STAGES];
    dv_st_t init;

    always_comb
    begin
        init.lane[0] = lane_init(in_data.vec.x);
        init.lane[1] = lane_init(in_data.vec.y);
        init.lane[2] = lane_init(in_data.vec.z);
        init.len     = in_data.root;
    end

    always_comb
    begin
        rdy[DIV_STAGES-1] = out_ready | ~v_reg[DIV_STAGES-1];
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = ~v_reg[k] | rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s_reg[0] <= dv_step(init);
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (rdy[k])
            begin
                s_reg[k] <= dv_step(s_reg[k-1]);
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    always_comb
    begin
        out_data.len = s_reg[DIV_STAGES-1].len;
        for (int i = 0; i < 3; i++)
        begin
            out_data.lane[i].q   = s_reg[DIV_STAGES-1].lane[i].q;
            out_data.lane[i].neg = s_reg[DIV_STAGES-1].lane[i].neg;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/v3n_checker.sv
// Port-level checker for the 3D vector normalizer and its bind.
`default_nettype none
module v3n_checker
    import v3n_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [UNIT_W-1:0] unit_x,
    input wire logic signed [UNIT_W-1:0] unit_y,
    input wire logic signed [UNIT_W-1:0] unit_z,
    input wire logic [ROOT_W-1:0]        magnitude,
    input wire logic                     zero_length
);

    localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
            && $stable(unit_z) && $stable(magnitude) && $stable(zero_length))
        else $error("output transaction changed while stalled");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> unit_x == 0 && unit_y == 0 && unit_z == 0
            && magnitude == 0)
        else $error("zero length result not cleared");

    a_nonzero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_length |-> magnitude != 0)
        else $error("zero magnitude without zero_length");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= UNIT_ONE && unit_x >= -UNIT_ONE
            && unit_y <= UNIT_ONE && unit_y >= -UNIT_ONE
            && unit_z <= UNIT_ONE && unit_z >= -UNIT_ONE)
        else $error("unit component out of range");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .unit_x      (unit_x),
    .unit_y      (unit_y),
    .unit_z      (unit_z),
    .magnitude   (magnitude),
    .zero_length (zero_length)
);
`default_nettype wire

FILE: dv/vector3_normalize_checker.sv
// Checker for the vector normalizer: predicts each result and compares.
module vector3_normalize_checker
    import v3n_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic signed [COMP_W-1:0] comp_x,
    input  wire logic signed [COMP_W-1:0] comp_y,
    input  wire logic signed [COMP_W-1:0] comp_z,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic signed [UNIT_W-1:0] unit_x,
    input  wire logic signed [UNIT_W-1:0] unit_y,
    input  wire logic signed [UNIT_W-1:0] unit_z,
    input  wire logic [ROOT_W-1:0]        magnitude,
    input  wire logic                     zero_length,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [UNIT_W-1:0] ux;
        logic [UNIT_W-1:0] uy;
        logic [UNIT_W-1:0] uz;
        logic [ROOT_W-1:0] mag;
        logic              zl;
    } norm_t;

    norm_t norm_q[$];

    function automatic logic [31:0] isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem && b != 0)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root[31:0];
    endfunction

    function automatic logic [UNIT_W-1:0] scale_comp(input logic signed [COMP_W-1:0] c,
                                                     input logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        m = c[COMP_W-1] ? 64'(-64'(c)) : 64'(c);
        q = (m << UNIT_FRAC) / len;
        if (c[COMP_W-1])
            q = -q;
        return q[UNIT_W-1:0];
    endfunction

    function automatic norm_t normalize(input logic signed [COMP_W-1:0] x,
                                        input logic signed [COMP_W-1:0] y,
                                        input logic signed [COMP_W-1:0] z);
        norm_t r;
        logic [63:0] s;
        logic [63:0] len;
        s = 64'($signed(x)) * 64'($signed(x)) + 64'($signed(y)) * 64'($signed(y))
            + 64'($signed(z)) * 64'($signed(z));
        len = 64'(isqrt(s));
        if (len == 0)
            r = '{ux: '0, uy: '0, uz: '0, mag: '0, zl: 1'b1};
        else
            r = '{ux: scale_comp(x, len), uy: scale_comp(y, len),
                  uz: scale_comp(z, len), mag: len[ROOT_W-1:0], zl: 1'b0};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        norm_t e;
        norm_t a;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                norm_q.push_back(normalize(comp_x, comp_y, comp_z));
            if (out_valid && out_ready)
            begin
                a = '{ux: unit_x, uy: unit_y, uz: unit_z, mag: magnitude, zl: zero_length};
                if (norm_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected transaction: %h", a);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = norm_q.pop_front();
                    if (e != a)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: exp x=%h y=%h z=%h m=%h zl=%b ",
                                      "act x=%h y=%h z=%h m=%h zl=%b"},
                                     e.ux, e.uy, e.uz, e.mag, e.zl,
                                     a.ux, a.uy, a.uz, a.mag, a.zl);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= norm_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the vector normalizer testbench: stimulus, stalls and verdict.
module testbench;
    import v3n_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [ROOT_W-1:0]        magnitude;
    logic                     zero_length;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles;
    bit                       stall_mode;

    localparam int IDLE_LIMIT = 4000;

    vector3_normalize dut (.*);
    vector3_normalize_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        out_ready = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                stall_mode <= ~stall_mode;
            out_ready <= stall_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        in_valid <= 1'b1;
        comp_x   <= x;
        comp_y   <= y;
        comp_z   <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int sent;
        idle_cycles = 0;
        rst_n    = 0;
        in_valid = 0;
        comp_x   = 0;
        comp_y   = 0;
        comp_z   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(16'h0000, 16'h0000, 16'h0000);
        send(16'h8000, 16'h8000, 16'h8000);
        send(16'h7fff, 16'h7fff, 16'h7fff);
        send(16'h8000, 16'h0000, 16'h0000);
        send(16'h0000, 16'h7fff, 16'h0000);
        send(16'h0000, 16'h0000, 16'h8000);
        send(16'h0001, 16'h0000, 16'h0000);
        send(16'hffff, 16'h0000, 16'h0000);
        send(16'h0001, 16'h0001, 16'h0001);
        send(16'hffff, 16'hffff, 16'hffff);
        send(16'h0100, 16'h0000, 16'h0000);
        send(16'h0003, 16'h0004, 16'h0000);
        send(16'h7fff, 16'h8000, 16'h0001);
        send(16'h5555, 16'haaaa, 16'h5555);
        gap(1);

        while (pending != 0)
            @(posedge clk);

        sent = 0;
        while (sent < 1536)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send(pick_comp(), pick_comp(), pick_comp());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                gap($urandom_range(1, 12));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_sqrt.sv
hw/rtl/v3n_div.sv
hw/rtl/vector3_normalize.sv
hw/rtl/v3n_checker.sv
dv/vector3_normalize_checker.sv
dv/testbench.sv
